@@ hdl/fkh_pkg.sv @@
// Shared types, register codes and term selection for the flow key hash.
package fkh_pkg;

  localparam int unsigned NumCells  = 13;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ProtoCell = NumCells - 1;
  localparam int unsigned WordTerms = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED     = 3'd0,
    REG_SCALE    = 3'd1,
    REG_HARDENER = 3'd2,
    REG_WORDMODE = 3'd3,
    REG_BYTESGN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] initiator_addr;
    logic [15:0] initiator_port;
    logic [31:0] responder_addr;
    logic [15:0] responder_port;
    logic [7:0]  proto_number;
  } key_t;

  typedef struct packed {
    logic [31:0] acc;
    key_t        key;
  } beat_t;

  // Address and port bytes in key order, byte 0 of the initiator address lowest.
  function automatic logic [95:0] fkh_key_bytes(key_t k);
    return {k.responder_port, k.responder_addr, k.initiator_port, k.initiator_addr};
  endfunction

  // Whether a given cell mixes a term in the current mode.
  function automatic logic fkh_active(int unsigned idx, logic word_mode);
    return !word_mode || (idx < WordTerms) || (idx == ProtoCell);
  endfunction

  // Term mixed by a given cell.
  function automatic logic [31:0] fkh_term(int unsigned idx, key_t k, logic word_mode,
                                           logic byte_signed);
    logic [95:0] bytes;
    logic [7:0]  b;
    logic [31:0] t;
    bytes = fkh_key_bytes(k);
    b     = 8'h00;
    t     = 32'h0;
    if (idx == ProtoCell) begin
      t = {24'h0, k.proto_number};
    end else if (word_mode) begin
      case (idx)
        0:       t = k.initiator_addr;
        1:       t = {16'h0, k.initiator_port};
        2:       t = k.responder_addr;
        3:       t = {16'h0, k.responder_port};
        default: t = 32'h0;
      endcase
    end else begin
      b = bytes[idx*8 +: 8];
      t = {{24{byte_signed & b[7]}}, b};
    end
    return t;
  endfunction

endpackage

@@ hdl/fkh_cell.sv @@
// One mix cell: acc * scale + term when active, else acc passed on; registered, with its own valid and ready.
module fkh_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fkh_pkg::beat_t  beat_i,
  input  logic [31:0]     term_i,
  input  logic            active_i,
  input  logic [31:0]     scale_i,
  input  logic            ready_i,
  output logic            ready_o,
  output logic            valid_o,
  output fkh_pkg::beat_t  beat_o
);
  import fkh_pkg::*;

  logic        valid_q;
  beat_t       beat_q, beat_d;
  logic [31:0] prod;

  assign ready_o = !valid_q || ready_i;
  assign prod    = beat_i.acc * scale_i;

  always_comb begin
    beat_d     = beat_i;
    if (active_i) begin
      beat_d.acc = prod + term_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

@@ hdl/flow_key_multiply_add_hash_unit.sv @@
// Top level of the flow key multiply-add hash: config registers and a row of mix cells.
//
//   channel   dir  handshake                    payload
//   key       in   key_valid_i / key_stall_o    initiator/responder addr+port, proto
//   hash      out  hash_valid_o / hash_stall_i  hash_value_o
//   cfg       in   cfg_we_i                     cfg_index_i, cfg_data_i
//
// One key beat per cycle while key_stall_o is low; each of the 13 cells registers it.
// Each cell holds one multiply by the scale and one add, so the mix chain
// length (13 byte-mode terms) sets the latency. Word mode uses the same
// chain, with the unused middle cells passing the accumulator through.
// Reset clears the valid bits of every cell; config registers take their
// reset values. A stall on the hash side backs up cell by cell, so empty
// cells still take new beats; key_stall_o rises only with a full chain.
module flow_key_multiply_add_hash_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fkh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fkh_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          key_valid_i,
  output logic                          key_stall_o,
  input  logic [31:0]                   initiator_addr_i,
  input  logic [15:0]                   initiator_port_i,
  input  logic [31:0]                   responder_addr_i,
  input  logic [15:0]                   responder_port_i,
  input  logic [7:0]                    proto_number_i,
  output logic                          hash_valid_o,
  input  logic                          hash_stall_i,
  output logic [31:0]                   hash_value_o
);
  import fkh_pkg::*;

  // Config registers
  logic [31:0] seed_q, scale_q, hardener_q;
  logic        word_mode_q, byte_signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q        <= 32'h0;
      scale_q       <= 32'h1;
      hardener_q    <= 32'h0;
      word_mode_q   <= 1'b0;
      byte_signed_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SEED:     seed_q        <= cfg_data_i[31:0];
        REG_SCALE:    scale_q       <= cfg_data_i[31:0];
        REG_HARDENER: hardener_q    <= cfg_data_i[31:0];
        REG_WORDMODE: word_mode_q   <= cfg_data_i[0];
        REG_BYTESGN:  byte_signed_q <= cfg_data_i[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Chain wiring: slot 0 is the input side, slot NumCells the output side
  logic  valid_w [NumCells+1];
  logic  ready_w [NumCells+1];
  beat_t beat_w  [NumCells+1];

  assign valid_w[0]                         = key_valid_i;
  assign beat_w[0].acc                      = seed_q;
  assign beat_w[0].key.initiator_addr       = initiator_addr_i;
  assign beat_w[0].key.initiator_port       = initiator_port_i;
  assign beat_w[0].key.responder_addr       = responder_addr_i;
  assign beat_w[0].key.responder_port       = responder_port_i;
  assign beat_w[0].key.proto_number         = proto_number_i;
  assign ready_w[NumCells]                  = !hash_stall_i;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic [31:0] term;
    logic        active;

    // term comes from the key the cell is about to register
    assign term   = fkh_term(g, beat_w[g].key, word_mode_q, byte_signed_q);
    assign active = fkh_active(g, word_mode_q);

    fkh_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_w[g]),
      .beat_i   (beat_w[g]),
      .term_i   (term),
      .active_i (active),
      .scale_i  (scale_q),
      .ready_i  (ready_w[g+1]),
      .ready_o  (ready_w[g]),
      .valid_o  (valid_w[g+1]),
      .beat_o   (beat_w[g+1])
    );
  end

  assign key_stall_o  = !ready_w[0];
  assign hash_valid_o = valid_w[NumCells];
  // user holds hardener fixed while beats are in flight (unenforced); XORed at port
  assign hash_value_o = beat_w[NumCells].acc ^ hardener_q;
endmodule

@@ hdl/fkh_checker.sv @@
// Port-level checks for the flow key hash unit, bound to the top level.
module fkh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [fkh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [fkh_pkg::CfgDataW-1:0]  cfg_data_i,
  input logic                          key_valid_i,
  input logic                          key_stall_o,
  input logic [31:0]                   initiator_addr_i,
  input logic [15:0]                   initiator_port_i,
  input logic [31:0]                   responder_addr_i,
  input logic [15:0]                   responder_port_i,
  input logic [7:0]                    proto_number_i,
  input logic                          hash_valid_o,
  input logic                          hash_stall_i,
  input logic [31:0]                   hash_value_o
);
  import fkh_pkg::*;

  // a held hash beat keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_valid_o && hash_stall_i |=> hash_valid_o && $stable(hash_value_o))
    else $error("hash beat changed under stall");

  // input back-pressure only comes from a blocked output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_stall_o |-> hash_valid_o && hash_stall_i)
    else $error("key stalled while hash side free");

  // chain comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !hash_valid_o && !key_stall_o)
    else $error("chain not empty after reset");

  // a beat entering a fully drained output path cannot be stalled
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hash_valid_o |-> !key_stall_o)
    else $error("key stalled with empty output");

endmodule

bind flow_key_multiply_add_hash_unit fkh_checker u_fkh_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the flow key multiply-add hash unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fkh_pkg::*;

  // One key beat per cycle, while the key side is not stalled, through a 13-cell chain.
  localparam int unsigned ChainDepth = 13;
  // Long enough for the chain to fill and push back on the key side.
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned PhaseKeys  = 44;

  // DUT ports; the inputs are all driven to known values from time zero.
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                key_valid_i      = 1'b0;
  logic                key_stall_o;
  logic [31:0]         initiator_addr_i = '0;
  logic [15:0]         initiator_port_i = '0;
  logic [31:0]         responder_addr_i = '0;
  logic [15:0]         responder_port_i = '0;
  logic [7:0]          proto_number_i   = '0;
  logic                hash_valid_o;
  logic                hash_stall_i     = 1'b0;
  logic [31:0]         hash_value_o;

  // Shadow copy of the config registers, at their reset values.
  logic [31:0] seed_r  = 32'h0;
  logic [31:0] scale_r = 32'h1;
  logic [31:0] hard_r  = 32'h0;
  logic        wmode_r = 1'b0;
  logic        bsign_r = 1'b1;

  // Hashes still owed by the DUT, oldest first.
  logic [31:0] pending_hashes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Sender pacing: beats left in the current burst, or back-to-back mode.
  int unsigned burst_left = 0;
  bit          dense      = 1'b0;

  // Receiver pacing: random stall segments plus an on-request hold-off.
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned segment_left = 0;
  int unsigned stall_pct    = 0;

  logic [31:0] expected_hash;

  flow_key_multiply_add_hash_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // Run guard: a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: holds off for a counted stretch on request, otherwise
  // stalls at a rate that changes from segment to segment (including
  // segments that never stall).
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      hash_stall_i <= 1'b1;
    end else begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(48, 4);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      segment_left--;
      hash_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: every accepted hash beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && hash_valid_o && !hash_stall_i) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value: no beat expected, got %h", hash_value_o);
        error_count++;
      end else begin
        expected_hash = pending_hashes.pop_front();
        if (hash_value_o !== expected_hash) begin
          $error("hash_value: expected %h, got %h", expected_hash, hash_value_o);
          error_count++;
        end
      end
    end
  end

  // Multiply-add over the key terms using the shadow config.
  function automatic logic [31:0] predict_hash(key_t k);
    logic [95:0] key_bytes;
    logic [7:0]  b;
    logic [31:0] acc;
    acc = seed_r;
    if (wmode_r) begin
      acc = acc * scale_r + k.initiator_addr;
      acc = acc * scale_r + {16'h0, k.initiator_port};
      acc = acc * scale_r + k.responder_addr;
      acc = acc * scale_r + {16'h0, k.responder_port};
    end else begin
      // Memory order: each field's low byte first, initiator before responder.
      key_bytes = {k.responder_port, k.responder_addr, k.initiator_port, k.initiator_addr};
      for (int i = 0; i < 12; i++) begin
        b   = key_bytes[8*i +: 8];
        acc = acc * scale_r + {{24{bsign_r & b[7]}}, b};
      end
    end
    // Protocol is always zero-extended, whatever the sign setting.
    acc = acc * scale_r + {24'h0, k.proto_number};
    return acc ^ hard_r;
  endfunction

  function automatic key_t make_key(logic [31:0] ia, logic [15:0] ip, logic [31:0] ra,
                                    logic [15:0] rp, logic [7:0] pr);
    key_t k;
    k.initiator_addr = ia;
    k.initiator_port = ip;
    k.responder_addr = ra;
    k.responder_port = rp;
    k.proto_number   = pr;
    return k;
  endfunction

  // Bytes lean toward the sign boundary and the all-zero/all-one values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic key_t random_key();
    return make_key({pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                    {pick_byte(), pick_byte()},
                    {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                    {pick_byte(), pick_byte()},
                    pick_byte());
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'h1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One key beat. Called at a falling edge; returns at a falling edge with
  // valid still high so the next beat can follow without a bubble.
  task automatic send_key(input key_t k);
    int unsigned gap;
    if (!dense) begin
      if (burst_left == 0) begin
        gap = $urandom_range(6);
        if (gap != 0) begin
          key_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
    end
    key_valid_i      <= 1'b1;
    initiator_addr_i <= k.initiator_addr;
    initiator_port_i <= k.initiator_port;
    responder_addr_i <= k.responder_addr;
    responder_port_i <= k.responder_port;
    proto_number_i   <= k.proto_number;
    do @(posedge clk_i); while (key_stall_o);
    pending_hashes.push_back(predict_hash(k));
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every owed hash to come out.
  task automatic wait_idle();
    key_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_hashes.size() != 0) @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    case (cfg_reg_e'(idx))
      REG_SEED:     seed_r  = data;
      REG_SCALE:    scale_r = data;
      REG_HARDENER: hard_r  = data;
      REG_WORDMODE: wmode_r = data[0];
      REG_BYTESGN:  bsign_r = data[0];
      default:      ;  // unmapped index, DUT ignores it
    endcase
  endtask

  task automatic apply_config(input logic [31:0] seed, input logic [31:0] scale,
                              input logic [31:0] hard, input logic [31:0] wmode,
                              input logic [31:0] bsign);
    write_reg(REG_SEED, seed);
    write_reg(REG_SCALE, scale);
    write_reg(REG_HARDENER, hard);
    write_reg(REG_WORDMODE, wmode);
    write_reg(REG_BYTESGN, bsign);
    cfg_we_i <= 1'b0;
  endtask

  // Reset config: byte mode, signed bytes, seed 0, scale 1, no hardener.
  task automatic test_reset_values();
    send_key(make_key(32'h0, 16'h0, 32'h0, 16'h0, 8'h00));
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_key(make_key(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080, 8'h80));
    send_key(make_key(32'h7F7F_7F7F, 16'h7F7F, 32'h7F7F_7F7F, 16'h7F7F, 8'h7F));
    send_key(make_key(32'h0403_0201, 16'h0605, 32'h0A09_0807, 16'h0C0B, 8'h0D));
    send_key(make_key(32'h0, 16'h0, 32'h0, 16'h0, 8'hFF));
  endtask

  // Byte mode at the config extremes, both byte sign settings.
  task automatic test_byte_mode_corners();
    wait_idle();
    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1);
    send_key(make_key(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080, 8'h80));
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    wait_idle();
    // Zero scale: only the protocol term survives.
    apply_config(32'h0, 32'h0, 32'h5A5A_5A5A, 32'h0, 32'h0);
    send_key(random_key());
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    wait_idle();
    // Unsigned bytes: the high bytes must not smear into the upper bits.
    apply_config(32'h1234_5678, 32'h0100_0193, 32'h0, 32'h0, 32'h0);
    send_key(make_key(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080, 8'h80));
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
  endtask

  task automatic test_word_mode_corners();
    wait_idle();
    apply_config(32'h0, 32'h1, 32'h0, 32'h1, 32'h1);
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_key(make_key(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080, 8'h80));
    wait_idle();
    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h1);
    send_key(make_key(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_key(make_key(32'h0, 16'h0, 32'h0, 16'h0, 8'h00));
    wait_idle();
    apply_config($urandom, 32'h9E37_79B1, $urandom, 32'h1, 32'h0);
    send_key(random_key());
    send_key(random_key());
  endtask

  // Upper bits of the one-bit registers and unmapped indexes must be dropped.
  task automatic test_ignored_writes();
    wait_idle();
    write_reg(REG_SEED, 32'hDEAD_BEEF);
    write_reg(REG_SCALE, 32'h0000_0003);
    write_reg(REG_HARDENER, 32'h0F0F_0F0F);
    write_reg(REG_WORDMODE, 32'hFFFF_FFFE);
    write_reg(REG_BYTESGN, 32'hFFFF_FFFF);
    for (int i = int'(REG_BYTESGN) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), $urandom);
    cfg_we_i <= 1'b0;
    send_key(make_key(32'h8080_8080, 16'h8080, 32'h8080_8080, 16'h8080, 8'h80));
    send_key(random_key());
  endtask

  // Receiver holds off long enough for the chain to fill and stall the key
  // side while the sender keeps offering beats back to back.
  task automatic test_input_backpressure();
    wait_idle();
    apply_config(pick_word(), pick_word(), pick_word(), $urandom, $urandom);
    hold_req = 1'b1;
    dense    = 1'b1;
    repeat (40) send_key(random_key());
    dense = 1'b0;
    wait_idle();
  endtask

  // Phases of random keys, each under a fresh random config.
  task automatic test_random_keys();
    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      apply_config(pick_word(), pick_word(), pick_word(), $urandom, $urandom);
      repeat (PhaseKeys) send_key(random_key());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_byte_mode_corners();
    test_word_mode_corners();
    test_ignored_writes();
    test_input_backpressure();
    test_random_keys();

    wait_idle();
    // Extra cycles to catch stray hash beats.
    repeat (2 * ChainDepth) @(negedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fkh_pkg.sv
hdl/fkh_cell.sv
hdl/flow_key_multiply_add_hash_unit.sv
hdl/fkh_checker.sv
bench/testbench.sv
